[rtl/core/csp_pkg.sv]
// shared types, constants and color name table for the color string parser
package csp_pkg;

	localparam int NAME_COUNT = 30;
	localparam int NAME_CHARS = 12;

	localparam logic [3:0] PH_DONE = 4'd12;
	localparam logic [3:0] PH_FAIL = 4'd13;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// classified character as it travels from front to back
	typedef struct packed {
		logic [7:0] chr;
		logic [7:0] lc;
		logic       is_nul;
		logic       is_space;
		logic       is_digit;
		logic [3:0] digit;
		logic [3:0] hex;
	} item_t;

	localparam logic [8*NAME_CHARS-1:0] NAME_TEXT [NAME_COUNT] = '{
		"aqua", "black", "blue", "chartreuse", "dodger", "fuchsia", "gold", "gray",
		"green", "grey", "lawn", "lime", "maroon", "navy", "olive", "orange",
		"orchid", "pink", "purple", "red", "rose", "silver", "slate", "spring",
		"steel", "teal", "turquoise", "violet", "white", "yellow"
	};

	localparam logic [23:0] NAME_RGB [NAME_COUNT] = '{
		24'hFFFF00, 24'h080808, 24'hFF0000, 24'h80FF80, 24'h0080FF, 24'hFF00FF,
		24'h80FFFF, 24'h808080, 24'h008000, 24'h808080, 24'h00FF80, 24'h00FF00,
		24'h000080, 24'h800000, 24'h008080, 24'h0080FF, 24'hFF80FF, 24'h8000FF,
		24'h800080, 24'h0000FF, 24'h8080FF, 24'hC0C0C0, 24'hFF8080, 24'h80FF00,
		24'hFF8000, 24'h808000, 24'hFFFF80, 24'hFF0080, 24'hFFFFFF, 24'h00FFFF
	};

	function automatic logic [3:0] name_len(input int k);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < NAME_CHARS; i++) begin
			if (NAME_TEXT[k][8*i +: 8] != 8'h00) n = n + 4'd1;
		end
		return n;
	endfunction

	// character at position idx, zero beyond the end of the name
	function automatic logic [7:0] name_char(input int k, input logic [3:0] idx);
		logic [3:0] len;
		logic [7:0] ch;
		len = name_len(k);
		ch  = '0;
		for (int i = 0; i < NAME_CHARS; i++) begin
			if ({1'b0, idx} < {1'b0, len} && 4'(i) == 4'(len - idx - 4'd1))
				ch = NAME_TEXT[k][8*i +: 8];
		end
		return ch;
	endfunction

endpackage

[rtl/core/csp_front.sv]
// front stage: accepts characters and classifies them into queue items
module csp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_char,
	output logic                push,
	input  logic                full,
	output csp_pkg::item_t      item
);

	logic           valid_s1;
	csp_pkg::item_t item_s1;
	csp_pkg::item_t cls;

	always_comb begin
		cls.chr      = in_char;
		cls.lc       = (in_char >= 8'h41 && in_char <= 8'h5A) ? in_char + 8'd32 : in_char;
		cls.is_nul   = (in_char == 8'h00);
		cls.is_space = (in_char == 8'h20) || (in_char >= 8'h09 && in_char <= 8'h0D);
		cls.is_digit = (in_char >= 8'h30 && in_char <= 8'h39);
		cls.digit    = 4'(in_char - 8'h30);
		if (in_char >= 8'h30 && in_char <= 8'h39) begin
			cls.hex = 4'(in_char - 8'h30);
		end else if (in_char >= 8'h41 && in_char <= 8'h46) begin
			cls.hex = 4'(in_char - 8'h37);
		end else if (in_char >= 8'h61 && in_char <= 8'h66) begin
			cls.hex = 4'(in_char - 8'h57);
		end else begin
			cls.hex = 4'd0;
		end
	end

	assign push     = valid_s1 && !full;
	assign in_ready = !valid_s1 || !full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

[rtl/core/csp_queue.sv]
// two-entry queue of classified items between front and back
module csp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  csp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output csp_pkg::item_t pop_item
);

	csp_pkg::item_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

[rtl/core/csp_back.sv]
// back stage: runs hex, decimal and name parsing and holds the result register
module csp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           not_empty,
	input  csp_pkg::item_t item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [23:0]    out_color
);

	localparam int NC = csp_pkg::NAME_COUNT;

	logic [3:0]    idx_q;
	logic          hash_q;
	logic [23:0]   hex_q;
	logic          comma_q;
	logic [3:0]    phase_q;
	logic [31:0]   acc_q;
	logic          neg_q;
	logic [7:0]    dec_q [3];
	logic [NC-1:0] cand_q;
	logic          ov_q;
	logic [23:0]   color_q;

	logic [3:0]    idx_d;
	logic          hash_d;
	logic [23:0]   hex_d;
	logic [3:0]    phase_d;
	logic [31:0]   acc_d;
	logic          neg_d;
	logic [7:0]    dec_d [3];
	logic [NC-1:0] cand_d;
	logic [23:0]   result;
	logic [35:0]   acc_x10;
	logic [7:0]    fin_byte;
	logic [1:0]    num;
	logic          out_free;
	logic          take_sep;

	assign out_free  = !ov_q || out_ready;
	assign pop       = not_empty && (!item.is_nul || out_free);
	assign out_valid = ov_q;
	assign out_color = color_q;
	assign num       = phase_q[3:2];
	assign acc_x10   = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {32'd0, item.digit};
	assign fin_byte  = neg_q ? 8'(-acc_q[7:0]) : acc_q[7:0];

	always_comb begin
		idx_d    = (idx_q != 4'd15) ? idx_q + 4'd1 : idx_q;
		hash_d   = hash_q || (idx_q == 4'd0 && item.chr == csp_pkg::CH_HASH);
		hex_d    = hex_q;
		phase_d  = phase_q;
		acc_d    = acc_q;
		neg_d    = neg_q;
		dec_d    = dec_q;
		take_sep = 1'b0;
		result   = '0;

		if (hash_d) begin
			unique case (idx_q)
				4'd1:    hex_d[7:4]   = item.hex;
				4'd2:    hex_d[3:0]   = item.hex;
				4'd3:    hex_d[15:12] = item.hex;
				4'd4:    hex_d[11:8]  = item.hex;
				4'd5:    hex_d[23:20] = item.hex;
				4'd6:    hex_d[19:16] = item.hex;
				default: hex_d = hex_q;
			endcase
		end

		// decimal pattern scanner
		if (phase_q < csp_pkg::PH_DONE) begin
			unique case (phase_q[1:0])
				2'd0, 2'd1: begin
					if (phase_q[1:0] == 2'd0 && item.is_space) begin
						phase_d = phase_q;
					end else if (phase_q[1:0] == 2'd0 &&
							(item.chr == csp_pkg::CH_PLUS || item.chr == csp_pkg::CH_MINUS)) begin
						neg_d   = (item.chr == csp_pkg::CH_MINUS);
						phase_d = {num, 2'd1};
					end else if (item.is_digit) begin
						acc_d   = {28'd0, item.digit};
						phase_d = {num, 2'd2};
					end else begin
						phase_d = csp_pkg::PH_FAIL;
					end
				end
				2'd2: begin
					if (item.is_digit) begin
						acc_d = (acc_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_x10[31:0];
					end else begin
						dec_d[num] = fin_byte;
						acc_d      = '0;
						neg_d      = 1'b0;
						if (num == 2'd2) begin
							phase_d = csp_pkg::PH_DONE;
						end else begin
							phase_d  = {num, 2'd3};
							take_sep = 1'b1;
						end
					end
				end
				default: take_sep = 1'b1;
			endcase
			if (take_sep && !item.is_space) begin
				phase_d = (item.chr == csp_pkg::CH_COMMA) ? {num + 2'd1, 2'd0} : csp_pkg::PH_FAIL;
			end
		end

		for (int k = 0; k < NC; k++) begin
			cand_d[k] = cand_q[k] && (idx_q < csp_pkg::name_len(k)) &&
				(csp_pkg::name_char(k, idx_q) == item.lc);
		end

		// end of string
		if (hash_q) begin
			result = (idx_q >= 4'd7) ? hex_q : 24'd0;
		end else if (comma_q) begin
			if (phase_q == 4'd10) begin
				result = {fin_byte, dec_q[1], dec_q[0]};
			end else if (phase_q == csp_pkg::PH_DONE) begin
				result = {dec_q[2], dec_q[1], dec_q[0]};
			end
		end else begin
			for (int k = NC - 1; k >= 0; k--) begin
				if (cand_q[k] && csp_pkg::name_len(k) == idx_q) result = csp_pkg::NAME_RGB[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			hash_q  <= 1'b0;
			hex_q   <= '0;
			comma_q <= 1'b0;
			phase_q <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			dec_q   <= '{default: '0};
			cand_q  <= '1;
			ov_q    <= 1'b0;
		end else begin
			if (pop && item.is_nul) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (pop) begin
				if (item.is_nul) begin
					idx_q   <= '0;
					hash_q  <= 1'b0;
					hex_q   <= '0;
					comma_q <= 1'b0;
					phase_q <= '0;
					acc_q   <= '0;
					neg_q   <= 1'b0;
					dec_q   <= '{default: '0};
					cand_q  <= '1;
				end else begin
					idx_q   <= idx_d;
					hash_q  <= hash_d;
					hex_q   <= hex_d;
					comma_q <= comma_q || (item.chr == csp_pkg::CH_COMMA);
					phase_q <= phase_d;
					acc_q   <= acc_d;
					neg_q   <= neg_d;
					dec_q   <= dec_d;
					cand_q  <= cand_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.is_nul) begin
			color_q <= result;
		end
	end

endmodule

[rtl/core/color_string_parser_unit.sv]
// top level of the color string parser: front, item queue and back
// a nul transaction reaches the output through the front register, the queue and the result register
// throughput: one character transaction per cycle unless a nul waits on a full result register,
// set by the back stage, which updates all parse state once per character
// the result register frees the back stage while a color waits to be taken
// reset: arst_n clears all control and parse state asynchronously
module color_string_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [23:0] color
);

	// front to queue
	logic           push;
	logic           full;
	csp_pkg::item_t push_item;

	// queue to back
	logic           pop;
	logic           not_empty;
	csp_pkg::item_t pop_item;

	// classify each character into a queue item
	csp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.push     (push),
		.full     (full),
		.item     (push_item)
	);

	// short queue lets front and back stall independently
	csp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_item  (pop_item)
	);

	// parse state and result register
	csp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.item      (pop_item),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_color (m_tdata)
	);

endmodule
